@@ sv/tpp_pkg.sv @@
package tpp_pkg;

  localparam int CW    = 32;
  localparam int FB    = 16;
  localparam int SZ_W  = 16;
  localparam int NL    = 6;
  localparam int NV    = 3;
  localparam int CEN_W = (CW > SZ_W + FB - 1) ? CW : SZ_W + FB - 1;
  localparam int RES_W = CEN_W + 2;
  localparam int CMP_W = RES_W + SZ_W + FB + 2;

  localparam logic signed [CMP_W-1:0] ONE_C = {{(CMP_W-1){1'b0}}, 1'b1} << FB;
  localparam logic signed [CMP_W-1:0] SMAX_C =
    ({{(CMP_W-1){1'b0}}, 1'b1} << (CW - 1)) - {{(CMP_W-1){1'b0}}, 1'b1};
  localparam logic [CW-1:0] NEG_ONE = {{(CW-FB){1'b1}}, {FB{1'b0}}};

  typedef enum logic [2:0] {
    REG_WIDTH, REG_HEIGHT, REG_CEN_U, REG_CEN_V, REG_FOCAL, REG_FOCAL_U, REG_FOCAL_V
  } cfg_idx_t;

  typedef struct packed {
    logic [SZ_W-1:0] width;
    logic [SZ_W-1:0] height;
    logic [CW-1:0]   cen_u;
    logic [CW-1:0]   cen_v;
    logic [CW-1:0]   focal;
    logic [CW-1:0]   focal_u;
    logic [CW-1:0]   focal_v;
  } cam_t;

  // one axis of one vertex on its way through the divider
  typedef struct packed {
    logic [CW-1:0]    a;
    logic [CW-1:0]    q;
    logic [CW-2:0]    z;
    logic             ok;
    logic             neg;
    logic [CEN_W-1:0] cen;
  } lane_t;

  typedef lane_t [NL-1:0] lanes_t;

  function automatic logic in_win(logic signed [RES_W-1:0] c, logic [SZ_W-1:0] size);
    logic signed [CMP_W-1:0] cx;
    logic signed [CMP_W-1:0] top;
    cx  = {{(CMP_W-RES_W){c[RES_W-1]}}, c};
    top = ($signed({{(CMP_W-SZ_W){1'b0}}, size}) - ONE_C[CMP_W-1:FB]) <<< FB;
    return (cx <= SMAX_C) && (cx >= ONE_C) && (cx <= top);
  endfunction

endpackage

@@ sv/tpp_front.sv @@
module tpp_front import tpp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cam_t                    cam,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [3*NV-1:0][CW-1:0] coords,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output lanes_t                  dn_lanes
);

  logic   v_r;
  lanes_t lanes_r, lanes_nxt;
  logic [CEN_W-1:0] cu, cv;
  logic [CW-1:0]    fu, fv;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_lanes = lanes_r;

  assign cu = (cam.cen_u != '0) ? CEN_W'(cam.cen_u) : CEN_W'(cam.width) << (FB - 1);
  assign cv = (cam.cen_v != '0) ? CEN_W'(cam.cen_v) : CEN_W'(cam.height) << (FB - 1);
  assign fu = (cam.focal_u != '0) ? cam.focal_u : cam.focal;
  assign fv = (cam.focal_v != '0) ? cam.focal_v : cam.focal;

  for (genvar k = 0; k < NL; k++) begin : g_lane
    logic [CW-1:0]   c, z, mag;
    logic [2*CW-1:0] prod;
    assign c    = coords[(k / 2) * 3 + (k % 2)];
    assign z    = coords[(k / 2) * 3 + 2];
    assign mag  = c[CW-1] ? (~c + 1'b1) : c;
    assign prod = (((k % 2) == 0) ? fu : fv) * mag;
    always_comb begin
      lanes_nxt[k].a   = prod[2*CW-1:CW];
      lanes_nxt[k].q   = prod[CW-1:0];
      lanes_nxt[k].z   = z[CW-2:0];
      lanes_nxt[k].ok  = !z[CW-1] && (z != '0);
      lanes_nxt[k].neg = c[CW-1];
      lanes_nxt[k].cen = ((k % 2) == 0) ? cu : cv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

@@ sv/tpp_cell.sv @@
module tpp_cell import tpp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  lanes_t up_lanes,
  output logic   dn_valid,
  input  logic   dn_ready,
  output lanes_t dn_lanes
);

  logic   v_r;
  lanes_t lanes_r, lanes_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_lanes = lanes_r;

  // one restoring step per lane: shift in the next dividend bit, subtract if it fits
  always_comb begin
    logic [CW:0] t, zx;
    logic        ge;
    lanes_nxt = up_lanes;
    for (int k = 0; k < NL; k++) begin
      t  = {up_lanes[k].a, up_lanes[k].q[CW-1]};
      zx = {2'b00, up_lanes[k].z};
      ge = t >= zx;
      lanes_nxt[k].a  = ge ? CW'(t - zx) : t[CW-1:0];
      lanes_nxt[k].q  = {up_lanes[k].q[CW-2:0], ge};
      // remainder at or above the divisor only at entry: quotient overflows
      lanes_nxt[k].ok = up_lanes[k].ok && (up_lanes[k].a < {1'b0, up_lanes[k].z});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

@@ sv/tpp_back.sv @@
module tpp_back import tpp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cam_t                 cam,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  lanes_t               up_lanes,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NL-1:0][CW-1:0] coord,
  output logic [NV-1:0]        seen,
  output logic                 face
);

  logic                          v1_r, v2_r, rdy2;
  logic signed [NL-1:0][RES_W-1:0] res_r, res_nxt;
  logic [NL-1:0]                 ok_r;
  logic [NL-1:0][CW-1:0]         coord_r, coord_nxt;
  logic [NV-1:0]                 seen_r, seen_nxt;

  assign rdy2     = !v2_r || out_ready;
  assign up_ready = !v1_r || rdy2;
  assign out_valid = v2_r;
  assign coord    = coord_r;
  assign seen     = seen_r;
  assign face     = &seen_r;

  always_comb begin
    logic signed [RES_W-1:0] cx, qx;
    for (int k = 0; k < NL; k++) begin
      cx = $signed({2'b00, up_lanes[k].cen});
      qx = $signed({{(RES_W-CW){1'b0}}, up_lanes[k].q});
      res_nxt[k] = up_lanes[k].neg ? cx - qx : cx + qx;
    end
  end

  always_comb begin
    for (int j = 0; j < NV; j++) begin
      seen_nxt[j] = ok_r[2*j] && ok_r[2*j+1] && in_win(res_r[2*j], cam.width) &&
                    in_win(res_r[2*j+1], cam.height);
      coord_nxt[2*j]   = seen_nxt[j] ? res_r[2*j][CW-1:0] : NEG_ONE;
      coord_nxt[2*j+1] = seen_nxt[j] ? res_r[2*j+1][CW-1:0] : NEG_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (up_ready) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
      for (int k = 0; k < NL; k++) begin
        ok_r[k] <= up_lanes[k].ok;
      end
    end
    if (rdy2 && v1_r) begin
      coord_r <= coord_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

@@ sv/triangle_pinhole_projection.sv @@
// Pinhole projection of one triangle per transfer.
// Input channel in_valid/in_ready carries three camera-space points (x, y, z,
// signed Q16.16). Output channel out_valid/out_ready carries pixel u/v for each
// vertex (Q16.16, -1.0 when not visible), a seen flag per vertex and
// face_projected when all three are seen.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the camera
// registers; cfg_ready is always high. Write only while no triangle is in flight.
// The pipeline is a focal-multiply stage, the 32-cell restoring divider chain with
// one quotient bit per cell, a centre-add stage and a window-test stage into the
// output register. A new triangle is taken every cycle while in_ready is high.
// Each stage holds its data when the stage after it cannot accept, so a stalled
// receiver fills the chain and in_ready drops only when every stage is occupied.
// Reset empties the pipeline and loads the register defaults: 1920x1080,
// centre from half the image size, focal length 1000.0.
module triangle_pinhole_projection import tpp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [CW-1:0] in_first_x,
  input  logic [CW-1:0] in_first_y,
  input  logic [CW-1:0] in_first_z,
  input  logic [CW-1:0] in_second_x,
  input  logic [CW-1:0] in_second_y,
  input  logic [CW-1:0] in_second_z,
  input  logic [CW-1:0] in_third_x,
  input  logic [CW-1:0] in_third_y,
  input  logic [CW-1:0] in_third_z,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CW-1:0] out_first_u,
  output logic [CW-1:0] out_first_v,
  output logic [CW-1:0] out_second_u,
  output logic [CW-1:0] out_second_v,
  output logic [CW-1:0] out_third_u,
  output logic [CW-1:0] out_third_v,
  output logic          out_first_seen,
  output logic          out_second_seen,
  output logic          out_third_seen,
  output logic          out_face_projected,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [CW-1:0] cfg_data
);

  cam_t cam_r;
  logic [3*NV-1:0][CW-1:0] coords;
  logic [NL-1:0][CW-1:0]   ocoord;
  logic [NV-1:0]           oseen;
  logic                    v_c [CW+1];
  logic                    r_c [CW+1];
  lanes_t                  l_c [CW+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.width   <= SZ_W'(1920);
      cam_r.height  <= SZ_W'(1080);
      cam_r.cen_u   <= '0;
      cam_r.cen_v   <= '0;
      cam_r.focal   <= CW'(1000) << FB;
      cam_r.focal_u <= '0;
      cam_r.focal_v <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_WIDTH:   cam_r.width   <= cfg_data[SZ_W-1:0];
        REG_HEIGHT:  cam_r.height  <= cfg_data[SZ_W-1:0];
        REG_CEN_U:   cam_r.cen_u   <= cfg_data;
        REG_CEN_V:   cam_r.cen_v   <= cfg_data;
        REG_FOCAL:   cam_r.focal   <= cfg_data;
        REG_FOCAL_U: cam_r.focal_u <= cfg_data;
        REG_FOCAL_V: cam_r.focal_v <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coords = {in_third_z, in_third_y, in_third_x, in_second_z, in_second_y,
                   in_second_x, in_first_z, in_first_y, in_first_x};

  tpp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cam      (cam_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .coords   (coords),
    .dn_valid (v_c[0]),
    .dn_ready (r_c[0]),
    .dn_lanes (l_c[0])
  );

  for (genvar i = 0; i < CW; i++) begin : g_cell
    tpp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v_c[i]),
      .up_ready (r_c[i]),
      .up_lanes (l_c[i]),
      .dn_valid (v_c[i+1]),
      .dn_ready (r_c[i+1]),
      .dn_lanes (l_c[i+1])
    );
  end

  tpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cam       (cam_r),
    .up_valid  (v_c[CW]),
    .up_ready  (r_c[CW]),
    .up_lanes  (l_c[CW]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .coord     (ocoord),
    .seen      (oseen),
    .face      (out_face_projected)
  );

  assign out_first_u     = ocoord[0];
  assign out_first_v     = ocoord[1];
  assign out_second_u    = ocoord[2];
  assign out_second_v    = ocoord[3];
  assign out_third_u     = ocoord[4];
  assign out_third_v     = ocoord[5];
  assign out_first_seen  = oseen[0];
  assign out_second_seen = oseen[1];
  assign out_third_seen  = oseen[2];

endmodule

@@ tb/triangle_pinhole_projection_tb.sv @@
`timescale 1ns / 100ps

module triangle_pinhole_projection_tb;
  import tpp_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [8:0][CW-1:0] pt;  // x,y,z of first, second, third vertex
  } tri_t;

  typedef struct packed {
    logic [5:0][CW-1:0] uv;
    logic [2:0]         seen;
    logic               face;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_fire = 1'b0;
  tri_t in_tri = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0][CW-1:0] out_uv;
  logic out_first_seen, out_second_seen, out_third_seen, out_face_projected;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  tri_t  pending_tris[$];
  proj_t expected_proj[$];
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;

  // camera copy, updated on every configuration transfer
  logic [15:0]   cam_width = 16'd1920;
  logic [15:0]   cam_height = 16'd1080;
  logic [CW-1:0] cam_cu = '0, cam_cv = '0;
  logic [CW-1:0] cam_focal = 32'd1000 << 16, cam_fu = '0, cam_fv = '0;

  always #10 clk = ~clk;

  triangle_pinhole_projection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_x(in_tri.pt[0]), .in_first_y(in_tri.pt[1]), .in_first_z(in_tri.pt[2]),
    .in_second_x(in_tri.pt[3]), .in_second_y(in_tri.pt[4]), .in_second_z(in_tri.pt[5]),
    .in_third_x(in_tri.pt[6]), .in_third_y(in_tri.pt[7]), .in_third_z(in_tri.pt[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_first_u(out_uv[0]), .out_first_v(out_uv[1]),
    .out_second_u(out_uv[2]), .out_second_v(out_uv[3]),
    .out_third_u(out_uv[4]), .out_third_v(out_uv[5]),
    .out_first_seen(out_first_seen), .out_second_seen(out_second_seen),
    .out_third_seen(out_third_seen), .out_face_projected(out_face_projected),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic longint center_u_eff();
    return (cam_cu != 0) ? longint'(cam_cu) : longint'(cam_width) << (FB - 1);
  endfunction

  function automatic longint center_v_eff();
    return (cam_cv != 0) ? longint'(cam_cv) : longint'(cam_height) << (FB - 1);
  endfunction

  function automatic longint focal_u_eff();
    return longint'((cam_fu != 0) ? cam_fu : cam_focal);
  endfunction

  function automatic longint focal_v_eff();
    return longint'((cam_fv != 0) ? cam_fv : cam_focal);
  endfunction

  // center +/- f*|c|/z, false when the quotient needs more than CW bits
  function automatic bit offset_axis(logic [CW-1:0] c, logic [CW-1:0] z, longint f,
                                     longint cen, output longint pix);
    logic [63:0] mag;
    logic [63:0] q;
    mag = c[CW-1] ? {32'd0, -c} : {32'd0, c};
    q = (64'(f) * mag) / {32'd0, z};
    pix = 0;
    if (q > 64'hFFFF_FFFF) return 1'b0;
    pix = c[CW-1] ? cen - longint'(q) : cen + longint'(q);
    return 1'b1;
  endfunction

  function automatic bit in_frame(longint c, logic [15:0] size);
    longint top;
    top = (longint'(size) - 1) * 65536;
    return c <= 64'sd2147483647 && c >= 65536 && c <= top;
  endfunction

  function automatic proj_t project_triangle(tri_t t);
    proj_t  r;
    longint pu, pv;
    bit     ok;
    for (int k = 0; k < 3; k++) begin
      ok = !t.pt[3*k+2][CW-1] && t.pt[3*k+2] != 0;
      if (ok) ok = offset_axis(t.pt[3*k], t.pt[3*k+2], focal_u_eff(), center_u_eff(), pu);
      if (ok) ok = offset_axis(t.pt[3*k+1], t.pt[3*k+2], focal_v_eff(), center_v_eff(), pv);
      if (ok) ok = in_frame(pu, cam_width) && in_frame(pv, cam_height);
      r.uv[2*k]   = ok ? pu[CW-1:0] : NEG_ONE;
      r.uv[2*k+1] = ok ? pv[CW-1:0] : NEG_ONE;
      r.seen[k]   = ok;
    end
    r.face = &r.seen;
    return r;
  endfunction

  // coordinate that lands near a target pixel at depth z
  function automatic logic [CW-1:0] aim_coord(longint target, longint cen, longint f,
                                              longint z);
    longint c;
    if (f == 0) return $urandom;
    c = ((target - cen) * z) / f;
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    return c[CW-1:0];
  endfunction

  function automatic void add_vertex(ref tri_t t, input int k, input int kind);
    longint z;
    case (kind)
      0: begin  // aimed into or just around the image
        z = $urandom_range(32'h00FF_FFFF, 1);
        t.pt[3*k+2] = z[CW-1:0];
        t.pt[3*k]   = aim_coord((longint'($urandom_range(cam_width + 2)) << FB)
                                - 65536 + $urandom_range(65535), center_u_eff(),
                                focal_u_eff(), z);
        t.pt[3*k+1] = aim_coord((longint'($urandom_range(cam_height + 2)) << FB)
                                - 65536 + $urandom_range(65535), center_v_eff(),
                                focal_v_eff(), z);
      end
      1: begin  // raw bits with the odd non-positive or extreme depth
        t.pt[3*k] = $urandom;
        t.pt[3*k+1] = $urandom;
        case ($urandom_range(3))
          0: t.pt[3*k+2] = '0;
          1: t.pt[3*k+2] = 32'h8000_0000;
          default: t.pt[3*k+2] = $urandom;
        endcase
      end
      default: begin  // small offsets, any positive depth
        t.pt[3*k] = $urandom_range(32'h0003_FFFF) - 32'h0002_0000;
        t.pt[3*k+1] = $urandom_range(32'h0003_FFFF) - 32'h0002_0000;
        t.pt[3*k+2] = $urandom_range(32'h7FFF_FFFF, 1);
      end
    endcase
  endfunction

  task automatic queue_random(int count);
    tri_t t;
    int   r;
    repeat (count) begin
      for (int k = 0; k < 3; k++) begin
        r = $urandom_range(99);
        add_vertex(t, k, (r < 75) ? 0 : (r < 88) ? 1 : 2);
      end
      pending_tris.push_back(t);
    end
  endtask

  task automatic queue_points(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    tri_t t;
    for (int k = 0; k < 3; k++) begin
      t.pt[3*k] = x;
      t.pt[3*k+1] = y;
      t.pt[3*k+2] = z;
    end
    pending_tris.push_back(t);
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_tris.size() != 0 || in_valid || expected_proj.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_camera(logic [15:0] w, logic [15:0] h, logic [CW-1:0] cu,
                              logic [CW-1:0] cv, logic [CW-1:0] f, logic [CW-1:0] fu,
                              logic [CW-1:0] fv);
    write_reg(REG_WIDTH, {16'd0, w});
    write_reg(REG_HEIGHT, {16'd0, h});
    write_reg(REG_CEN_U, cu);
    write_reg(REG_CEN_V, cv);
    write_reg(REG_FOCAL, f);
    write_reg(REG_FOCAL_U, fu);
    write_reg(REG_FOCAL_V, fv);
  endtask

  // remember whether the last rising edge took an input transfer
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
  end

  // sender
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_tris.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tri <= pending_tris.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // predict on input transfer, check on output transfer, track camera writes
  always @(posedge clk) begin
    proj_t got, want;
    if (rst_n) begin
      if (in_valid && in_ready) expected_proj.push_back(project_triangle(in_tri));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:   cam_width = cfg_data[15:0];
          REG_HEIGHT:  cam_height = cfg_data[15:0];
          REG_CEN_U:   cam_cu = cfg_data;
          REG_CEN_V:   cam_cv = cfg_data;
          REG_FOCAL:   cam_focal = cfg_data;
          REG_FOCAL_U: cam_fu = cfg_data;
          REG_FOCAL_V: cam_fv = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.uv = out_uv;
        got.seen = {out_third_seen, out_second_seen, out_first_seen};
        got.face = out_face_projected;
        if (expected_proj.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer uv=%h", got.uv);
        end else begin
          want = expected_proj.pop_front();
          if (got.uv !== want.uv || got.seen !== want.seen || got.face !== want.face) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp uv=%h seen=%b face=%b / got uv=%h seen=%b face=%b",
                       want.uv, want.seen, want.face, got.uv, got.seen, got.face);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("triangle_pinhole_projection_tb failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 10;
    recv_idle_pct = 62;
    // defaults: center, depth signs, quotient overflow, extremes
    queue_points('0, '0, '0);
    queue_points('0, '0, 32'h0001_0000);
    queue_points('0, '0, 32'hFFFF_0000);
    queue_points('0, '0, 32'h8000_0000);
    queue_points('0, '0, 32'h7FFF_FFFF);
    queue_points(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    queue_points(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_points(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    queue_points(32'h0000_EB85, 32'h0000_8000, 32'h0001_0000);
    queue_points(32'hFFFF_147B, 32'hFFFF_7AE2, 32'h0001_0000);
    queue_points(32'h0003_D1EB, 32'h0002_2B85, 32'h0001_0000);
    queue_random(6);
    wait_idle();

    // per-axis focal, explicit center, out-of-range index ignored
    write_camera(16'd640, 16'd480, 32'h0140_0000, 32'h00F0_0000, 32'h0100_0000,
                 32'h0200_0000, 32'h0080_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    queue_points(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    queue_random(150);
    wait_idle();

    write_camera(16'hFFFF, 16'hFFFF, '0, '0, 32'h0000_1000, '0, '0);
    queue_random(150);
    wait_idle();

    send_idle_pct = 62;
    recv_idle_pct = 10;
    // zero image size and a unit image see nothing
    write_camera(16'd0, 16'd1, '0, '0, 32'h0001_0000, '0, '0);
    queue_random(40);
    wait_idle();

    // zero focal puts every vertex with a valid depth on the center
    write_camera(16'd3, 16'd3, '0, '0, '0, '0, '0);
    queue_random(60);
    wait_idle();

    write_camera(16'd2000, 16'd100, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF,
                 '0, 32'hFFFF_FFFF);
    queue_random(200);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_camera(16'd1920, 16'd1080, '0, '0, 32'h03E8_0000, '0, '0);
    queue_random(250);
    wait_idle();

    write_camera(16'd256, 16'd65535, 32'h0080_8000, '0, 32'h0000_0001,
                 32'h0020_0000, '0);
    queue_random(200);
    wait_idle();

    if (mismatches == 0) begin
      $display("triangle_pinhole_projection_tb passed");
    end else begin
      $display("triangle_pinhole_projection_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tpp_pkg.sv
sv/tpp_front.sv
sv/tpp_cell.sv
sv/tpp_back.sv
sv/triangle_pinhole_projection.sv
tb/triangle_pinhole_projection_tb.sv
